/* hdl/dqmc_pkg.sv */
// Package for the double-ended queue: sizes, opcodes, ring helpers and store types.
`default_nettype none
package dqmc_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_COUNT      = 3'd4;
   localparam logic [2:0] OP_QUERY      = 3'd5;

   localparam logic [1:0] FAULT_NONE      = 2'd0;
   localparam logic [1:0] FAULT_OVERFLOW  = 2'd1;
   localparam logic [1:0] FAULT_UNDERFLOW = 2'd2;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic     en;
      idx_type  addr;
      word_type data;
   } store_wr_type;

   // a and b both below DEPTH
   function automatic idx_type ring_add(input idx_type a, input idx_type b);
      logic [IDX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (IDX_W+1)'(DEPTH)) begin
         s = s - (IDX_W+1)'(DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   function automatic idx_type ring_prev(input idx_type a);
      if (a == '0) begin
         return IDX_W'(DEPTH - 1);
      end
      return a - IDX_W'(1);
   endfunction

endpackage
`default_nettype wire

/* hdl/deque_with_match_count.sv */
// Top level of the bounded double-ended queue with match counter.
//
// Bounded deque of 16 signed 32-bit words held in a ring in a single-port-read
// memory. Each request transaction carries a command in req_tuser and a word in
// req_tdata and yields exactly one response transaction with the front and back
// words, occupancy, match count, empty flag and fault code. The block takes one
// command at a time. Push, pop and query pass through execute, front read, back
// read and result states and load the response register on leaving the result
// state, which waits while the output register still holds an untaken response;
// a count command adds a scan state before the front read, in which the one
// comparator steps through the held entries one memory read per cycle.
// A response waiting in the output register does not stop the next command
// being accepted.
`default_nettype none
module deque_with_match_count
   import dqmc_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // value[31:0]
   input  wire  [2:0]  req_tuser,   // opcode[2:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [79:0] rsp_tdata    // front_value[31:0], back_value[63:32],
                                    // occupancy[68:64], match_count[73:69],
                                    // is_empty[74], fault[76:75], zero[79:77]
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_FRONT = 3'd3;
   localparam logic [2:0] S_BACK  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]   state_ff, state_in;
   idx_type      front_ff, front_in;
   cnt_type      total_ff, total_in;
   logic [2:0]   op_ff;
   word_type     val_ff;
   logic [1:0]   fault_ff, fault_in;
   cnt_type      match_ff, match_in;
   cnt_type      scan_ff, scan_in;
   logic         cmp_vld_ff, cmp_vld_in;
   word_type     fv_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [79:0]  rsp_data_ff;

   store_wr_type wr;
   idx_type      rd_addr;
   word_type     rd_data;
   idx_type      back_idx;
   logic         issue;
   logic         accept;
   logic         load;
   logic         empty;
   word_type     fv_out, bv_out;

   dqmc_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign back_idx   = ring_add(front_ff, IDX_W'(total_ff - CNT_W'(1)));
   assign issue      = (scan_ff < total_ff);
   assign load       = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   assign empty      = (total_ff == '0);
   assign fv_out     = empty ? '1 : fv_ff;
   assign bv_out     = empty ? '1 : rd_data;

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      total_in     = total_ff;
      fault_in     = fault_ff;
      match_in     = match_ff;
      scan_in      = scan_ff;
      cmp_vld_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      wr.en        = 1'b0;
      wr.addr      = front_ff;
      wr.data      = val_ff;
      rd_addr      = front_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            fault_in = FAULT_NONE;
            match_in = '0;
            scan_in  = '0;
            state_in = S_FRONT;
            unique case (op_ff) inside
               OP_PUSH_FRONT, OP_PUSH_BACK: begin
                  if (total_ff >= CNT_W'(DEPTH)) begin
                     fault_in = FAULT_OVERFLOW;
                  end else begin
                     wr.en    = 1'b1;
                     total_in = total_ff + CNT_W'(1);
                     if (op_ff == OP_PUSH_FRONT) begin
                        front_in = ring_prev(front_ff);
                        wr.addr  = ring_prev(front_ff);
                     end else begin
                        wr.addr  = ring_add(front_ff, IDX_W'(total_ff));
                     end
                  end
               end
               OP_POP_FRONT, OP_POP_BACK: begin
                  if (empty) begin
                     fault_in = FAULT_UNDERFLOW;
                  end else begin
                     total_in = total_ff - CNT_W'(1);
                     if (op_ff == OP_POP_FRONT) begin
                        front_in = ring_add(front_ff, IDX_W'(1));
                     end
                  end
               end
               OP_COUNT: begin
                  state_in = S_SCAN;
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            rd_addr    = ring_add(front_ff, IDX_W'(scan_ff));
            cmp_vld_in = issue;
            if (issue) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (cmp_vld_ff && (rd_data == val_ff)) begin
               match_in = match_ff + CNT_W'(1);
            end
            if (!issue && !cmp_vld_ff) begin
               state_in = S_FRONT;
            end
         end
         S_FRONT: begin
            rd_addr  = front_ff;
            state_in = S_BACK;
         end
         S_BACK: begin
            rd_addr  = back_idx;
            state_in = S_DONE;
         end
         S_DONE: begin
            rd_addr = back_idx;
            if (load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         total_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         total_ff     <= total_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fault_ff <= fault_in;
      match_ff <= match_in;
      scan_ff  <= scan_in;
      if (accept) begin
         op_ff  <= req_tuser;
         val_ff <= req_tdata;
      end
      if (state_ff == S_BACK) begin
         fv_ff <= rd_data;
      end
      if (load) begin
         rsp_data_ff <= {3'b000, fault_ff, empty, 5'(match_ff), 5'(total_ff),
                         bv_out, fv_out};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

/* hdl/dqmc_store.sv */
// Entry ring store: one write port, one read port with registered data.
`default_nettype none
module dqmc_store
   import dqmc_pkg::*;
(
   input  wire               clock,
   input  wire store_wr_type wr,
   input  wire idx_type      rd_addr,
   output word_type          rd_data
);

   word_type mem [DEPTH];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the bounded deque with match counter.
`timescale 1ns / 100ps

module tb;
   import dqmc_pkg::*;

   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
   localparam int RANDOM_ITEMS = 350;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [31:0] front_value;
      logic [31:0] back_value;
      logic [4:0]  occupancy;
      logic [4:0]  match_count;
      logic        is_empty;
      logic [1:0]  fault;
   } deque_status;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] value;
      int          reps;
      bit          fixed;
      deque_status want;
   } cmd_row;

   localparam deque_status NO_STATUS = '0;
   localparam deque_status EMPTY_STATUS =
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 5'd0, 1'b1, FAULT_NONE};
   localparam deque_status UNDERFLOW_STATUS =
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 5'd0, 1'b1, FAULT_UNDERFLOW};
   localparam deque_status OVERFLOW_STATUS =
      '{32'h7FFF_FFFF, 32'h0000_0005, 5'd16, 5'd0, 1'b0, FAULT_OVERFLOW};

   localparam int NUM_ROWS = 24;
   localparam cmd_row DIRECTED [NUM_ROWS] = '{
      '{OP_QUERY,      32'h0000_0000, 1,  1'b1, EMPTY_STATUS},
      '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b1, UNDERFLOW_STATUS},
      '{OP_POP_BACK,   32'hFFFF_FFFF, 1,  1'b1, UNDERFLOW_STATUS},
      '{OP_COUNT,      32'hFFFF_FFFF, 1,  1'b1, EMPTY_STATUS},
      '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1,  1'b1,
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1, 5'd0, 1'b0, FAULT_NONE}},
      '{OP_PUSH_FRONT, 32'h8000_0000, 1,  1'b1,
        '{32'h8000_0000, 32'h7FFF_FFFF, 5'd2, 5'd0, 1'b0, FAULT_NONE}},
      '{OP_PUSH_BACK,  32'hFFFF_FFFF, 1,  1'b0, NO_STATUS},
      '{OP_COUNT,      32'hFFFF_FFFF, 1,  1'b0, NO_STATUS},
      '{OP_SPARE_6,    32'h1234_5678, 1,  1'b0, NO_STATUS},
      '{OP_SPARE_7,    32'h8000_0000, 1,  1'b0, NO_STATUS},
      '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b0, NO_STATUS},
      '{OP_POP_BACK,   32'h0000_0000, 1,  1'b0, NO_STATUS},
      '{OP_PUSH_BACK,  32'h0000_0005, 15, 1'b0, NO_STATUS},
      '{OP_COUNT,      32'h0000_0005, 1,  1'b0, NO_STATUS},
      '{OP_PUSH_BACK,  32'h0000_0001, 1,  1'b1, OVERFLOW_STATUS},
      '{OP_PUSH_FRONT, 32'h0000_0001, 1,  1'b1, OVERFLOW_STATUS},
      '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b0, NO_STATUS},
      '{OP_PUSH_FRONT, 32'h0000_0005, 1,  1'b0, NO_STATUS},
      '{OP_COUNT,      32'h0000_0005, 1,  1'b1,
        '{32'h0000_0005, 32'h0000_0005, 5'd16, 5'd16, 1'b0, FAULT_NONE}},
      '{OP_COUNT,      32'h0000_0000, 1,  1'b0, NO_STATUS},
      '{OP_POP_BACK,   32'h0000_0000, 16, 1'b0, NO_STATUS},
      '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b1, UNDERFLOW_STATUS},
      '{OP_PUSH_FRONT, 32'h0000_0000, 1,  1'b0, NO_STATUS},
      '{OP_POP_BACK,   32'h0000_0000, 1,  1'b0, NO_STATUS}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // value[31:0]
   logic [2:0]  req_tuser = '0;   // opcode[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // front_value, back_value, occupancy, match_count,
                                  // is_empty, fault, zero padding

   deque_status pending_status [$];
   logic [31:0] ring_mem [DEPTH];
   int          head_idx = 0;
   int          held = 0;
   int          errors = 0;
   int          stall_cycles = 0;
   bit          quiet = 1'b0;

   deque_with_match_count dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic deque_status apply_command(input logic [2:0] op,
                                                 input logic [31:0] value);
      deque_status st;
      int          i;
      st = '0;
      st.fault = FAULT_NONE;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (held >= DEPTH) begin
               st.fault = FAULT_OVERFLOW;
            end else if (op == OP_PUSH_FRONT) begin
               head_idx = (head_idx + DEPTH - 1) % DEPTH;
               ring_mem[head_idx] = value;
               held++;
            end else begin
               ring_mem[(head_idx + held) % DEPTH] = value;
               held++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (held == 0) begin
               st.fault = FAULT_UNDERFLOW;
            end else begin
               if (op == OP_POP_FRONT) head_idx = (head_idx + 1) % DEPTH;
               held--;
            end
         end
         OP_COUNT: begin
            for (i = 0; i < held; i++) begin
               if (ring_mem[(head_idx + i) % DEPTH] == value) st.match_count++;
            end
         end
         default: ;
      endcase
      st.occupancy = 5'(held);
      st.is_empty = (held == 0);
      if (held == 0) begin
         st.front_value = 32'hFFFF_FFFF;
         st.back_value = 32'hFFFF_FFFF;
      end else begin
         st.front_value = ring_mem[head_idx];
         st.back_value = ring_mem[(head_idx + held - 1) % DEPTH];
      end
      return st;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   // one transaction on the request side; entered and left at a falling edge
   task automatic send_command(input logic [2:0] op, input logic [31:0] value,
                               input bit fixed, input deque_status want);
      int          gap;
      deque_status st;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      st = apply_command(op, value);
      pending_status.insert(pending_status.size(), fixed ? want : st);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   always @(posedge clock) begin
      deque_status want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_status.size() == 0) begin
            $error("response transaction with nothing outstanding: %0h", rsp_tdata);
            errors++;
         end else begin
            want = pending_status[0];
            pending_status.delete(0);
            check_field("front_value", want.front_value, rsp_tdata[31:0]);
            check_field("back_value", want.back_value, rsp_tdata[63:32]);
            check_field("occupancy", 32'(want.occupancy), 32'(rsp_tdata[68:64]));
            check_field("match_count", 32'(want.match_count), 32'(rsp_tdata[73:69]));
            check_field("is_empty", 32'(want.is_empty), 32'(rsp_tdata[74]));
            check_field("fault", 32'(want.fault), 32'(rsp_tdata[76:75]));
         end
      end
   end

   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (quiet) begin
            rsp_tready <= 1'b1;
         end else if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
            hold = pick_gap();
         end
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("** deque_with_match_count: FAILED **");
      $finish;
   end

   initial begin
      int          row;
      int          k;
      int          sent;
      int          phase_len;
      int          bias;
      int          r;
      logic [2:0]  op;
      logic [31:0] value;
      logic [31:0] pool [4];

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (row = 0; row < NUM_ROWS; row++) begin
         for (k = 0; k < DIRECTED[row].reps; k++) begin
            send_command(DIRECTED[row].op, DIRECTED[row].value,
                         DIRECTED[row].fixed, DIRECTED[row].want);
         end
      end

      // hold off until the block has answered everything
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_status.size() != 0) @(negedge clock);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(10, 40);
         bias = $urandom_range(0, 2);   // fill, drain, mixed
         quiet = ($urandom_range(0, 4) == 0);
         pool[0] = $urandom();
         pool[1] = $urandom();
         pool[2] = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         pool[3] = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
         for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
            r = $urandom_range(0, 99);
            if (bias == 0) begin
               op = (r < 75) ? 3'($urandom_range(0, 1)) :
                    (r < 88) ? OP_COUNT : 3'($urandom_range(2, 7));
            end else if (bias == 1) begin
               op = (r < 75) ? 3'($urandom_range(2, 3)) :
                    (r < 88) ? OP_COUNT : 3'($urandom_range(0, 7));
            end else begin
               op = 3'($urandom_range(0, 7));
            end
            value = ($urandom_range(0, 1) != 0) ? pool[$urandom_range(0, 3)] : $urandom();
            send_command(op, value, 1'b0, NO_STATUS);
            sent++;
         end
         if ($urandom_range(0, 5) == 0) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (pending_status.size() != 0) @(negedge clock);
         end
      end

      req_tvalid <= 1'b0;
      quiet = 1'b0;
      while (pending_status.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("** deque_with_match_count: PASSED **");
      end else begin
         $display("** deque_with_match_count: FAILED **");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/dqmc_pkg.sv
hdl/dqmc_store.sv
hdl/deque_with_match_count.sv
test/tb.sv
